FILE: rtl/huffman_table_builder_codec_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Huffman engine
// Concurrent assertion forms used by the engine's datapath.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_BUILDER_CODEC_TOP_MACROS_SVH
`define HUFFMAN_TABLE_BUILDER_CODEC_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HBC_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define HBC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hbc_pkg.sv
// ---------------------------------------------------------------------------
// Huffman engine package
// Field widths, request kinds, controller states and the command and status
// bundles between controller and datapath.
// ---------------------------------------------------------------------------
package hbc_pkg;

   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int CODE_W = 64;
   localparam int LEN_W  = 7;
   localparam int SYM_W  = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 3'd0,
      KIND_COUNT  = 3'd1,
      KIND_BUILD  = 3'd2,
      KIND_ENCODE = 3'd3,
      KIND_DECODE = 3'd4
   } hbc_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_INIT_RD,
      ST_INIT_WR,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_MERGE_LO,
      ST_MERGE_RD,
      ST_MERGE_HI,
      ST_WALK_INIT,
      ST_WALK_RD,
      ST_WALK_L,
      ST_WALK_R,
      ST_BUILT,
      ST_ENC_RD,
      ST_ENC_CAP,
      ST_DEC_RD,
      ST_DEC_CAP,
      ST_RESP
   } hbc_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLEAR,
      OP_CNT_RD,
      OP_CNT_WR,
      OP_INIT_RD,
      OP_INIT_WR,
      OP_SCAN,
      OP_SCAN_TAIL,
      OP_MERGE_LO,
      OP_MERGE_RD,
      OP_MERGE_HI,
      OP_WALK_INIT,
      OP_WALK_RD,
      OP_WALK_L,
      OP_WALK_R,
      OP_BUILT,
      OP_ENC_RD,
      OP_ENC_CAP,
      OP_DEC_RD,
      OP_DEC_CAP,
      OP_PUSH
   } hbc_op_type;

   typedef struct packed {
      hbc_op_type op;
      logic       req_ready;
   } hbc_cmd_type;

   typedef struct packed {
      logic         req_valid;
      hbc_kind_type req_kind;
      logic         req_sym_ok;
      logic         built;
      logic         init_last;
      logic         scan_last;
      logic         count_one;
      logic         walk_last;
      logic         rsp_free;
   } hbc_status_type;

endpackage

FILE: rtl/hbc_if.sv
// ---------------------------------------------------------------------------
// Huffman engine channels
// Request and response channels with valid/ready handshake and payload.
// ---------------------------------------------------------------------------
interface hbc_req_if;
   logic                       valid;
   logic                       ready;
   logic [hbc_pkg::KIND_W-1:0] kind;
   logic [hbc_pkg::BYTE_W-1:0] byte_value;
   logic                       code_bit;

   modport source (output valid, kind, byte_value, code_bit, input ready);
   modport sink   (input valid, kind, byte_value, code_bit, output ready);
endinterface

interface hbc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       status;
   logic [hbc_pkg::CODE_W-1:0] code_bits;
   logic [hbc_pkg::LEN_W-1:0]  code_length;
   logic [hbc_pkg::SYM_W-1:0]  symbol;
   logic                       symbol_valid;

   modport source (output valid, status, code_bits, code_length, symbol, symbol_valid,
                   input ready);
   modport sink   (input valid, status, code_bits, code_length, symbol, symbol_valid,
                   output ready);
endinterface

FILE: rtl/hbc_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module hbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/hbc_ctrl.sv
// ---------------------------------------------------------------------------
// Huffman engine controller
// Sequences counting, tree build, code walk, encode and decode steps.
// ---------------------------------------------------------------------------
module hbc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  hbc_pkg::hbc_status_type status,
   output hbc_pkg::hbc_cmd_type    cmd
);

   hbc_pkg::hbc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbc_pkg::ST_IDLE: begin
            if (status.req_valid) begin
               case (status.req_kind)
                  hbc_pkg::KIND_CLEAR:  state_in = hbc_pkg::ST_CLEAR;
                  hbc_pkg::KIND_COUNT:  state_in = hbc_pkg::ST_CNT_RD;
                  hbc_pkg::KIND_BUILD:  state_in = hbc_pkg::ST_INIT_RD;
                  hbc_pkg::KIND_ENCODE: state_in = (status.built && status.req_sym_ok) ?
                                                   hbc_pkg::ST_ENC_RD : hbc_pkg::ST_RESP;
                  hbc_pkg::KIND_DECODE: state_in = status.built ?
                                                   hbc_pkg::ST_DEC_RD : hbc_pkg::ST_RESP;
                  default:              state_in = hbc_pkg::ST_RESP;
               endcase
            end
         end
         hbc_pkg::ST_CLEAR:     state_in = hbc_pkg::ST_RESP;
         hbc_pkg::ST_CNT_RD:    state_in = hbc_pkg::ST_CNT_WR;
         hbc_pkg::ST_CNT_WR:    state_in = hbc_pkg::ST_RESP;
         hbc_pkg::ST_INIT_RD:   state_in = hbc_pkg::ST_INIT_WR;
         hbc_pkg::ST_INIT_WR:   state_in = status.init_last ? hbc_pkg::ST_SCAN :
                                                              hbc_pkg::ST_INIT_RD;
         hbc_pkg::ST_SCAN:      state_in = status.scan_last ? hbc_pkg::ST_SCAN_TAIL :
                                                              hbc_pkg::ST_SCAN;
         hbc_pkg::ST_SCAN_TAIL: state_in = hbc_pkg::ST_MERGE_LO;
         hbc_pkg::ST_MERGE_LO:  state_in = hbc_pkg::ST_MERGE_RD;
         hbc_pkg::ST_MERGE_RD:  state_in = hbc_pkg::ST_MERGE_HI;
         hbc_pkg::ST_MERGE_HI:  state_in = status.count_one ? hbc_pkg::ST_WALK_INIT :
                                                              hbc_pkg::ST_SCAN;
         hbc_pkg::ST_WALK_INIT: state_in = hbc_pkg::ST_WALK_RD;
         hbc_pkg::ST_WALK_RD:   state_in = hbc_pkg::ST_WALK_L;
         hbc_pkg::ST_WALK_L:    state_in = hbc_pkg::ST_WALK_R;
         hbc_pkg::ST_WALK_R:    state_in = status.walk_last ? hbc_pkg::ST_BUILT :
                                                              hbc_pkg::ST_WALK_RD;
         hbc_pkg::ST_BUILT:     state_in = hbc_pkg::ST_RESP;
         hbc_pkg::ST_ENC_RD:    state_in = hbc_pkg::ST_ENC_CAP;
         hbc_pkg::ST_ENC_CAP:   state_in = hbc_pkg::ST_RESP;
         hbc_pkg::ST_DEC_RD:    state_in = hbc_pkg::ST_DEC_CAP;
         hbc_pkg::ST_DEC_CAP:   state_in = hbc_pkg::ST_RESP;
         hbc_pkg::ST_RESP:      state_in = status.rsp_free ? hbc_pkg::ST_IDLE :
                                                             hbc_pkg::ST_RESP;
         default:               state_in = hbc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.req_ready = 1'b0;
      cmd.op        = hbc_pkg::OP_NONE;
      case (state_ff)
         hbc_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.op        = hbc_pkg::OP_ACCEPT;
         end
         hbc_pkg::ST_CLEAR:     cmd.op = hbc_pkg::OP_CLEAR;
         hbc_pkg::ST_CNT_RD:    cmd.op = hbc_pkg::OP_CNT_RD;
         hbc_pkg::ST_CNT_WR:    cmd.op = hbc_pkg::OP_CNT_WR;
         hbc_pkg::ST_INIT_RD:   cmd.op = hbc_pkg::OP_INIT_RD;
         hbc_pkg::ST_INIT_WR:   cmd.op = hbc_pkg::OP_INIT_WR;
         hbc_pkg::ST_SCAN:      cmd.op = hbc_pkg::OP_SCAN;
         hbc_pkg::ST_SCAN_TAIL: cmd.op = hbc_pkg::OP_SCAN_TAIL;
         hbc_pkg::ST_MERGE_LO:  cmd.op = hbc_pkg::OP_MERGE_LO;
         hbc_pkg::ST_MERGE_RD:  cmd.op = hbc_pkg::OP_MERGE_RD;
         hbc_pkg::ST_MERGE_HI:  cmd.op = hbc_pkg::OP_MERGE_HI;
         hbc_pkg::ST_WALK_INIT: cmd.op = hbc_pkg::OP_WALK_INIT;
         hbc_pkg::ST_WALK_RD:   cmd.op = hbc_pkg::OP_WALK_RD;
         hbc_pkg::ST_WALK_L:    cmd.op = hbc_pkg::OP_WALK_L;
         hbc_pkg::ST_WALK_R:    cmd.op = hbc_pkg::OP_WALK_R;
         hbc_pkg::ST_BUILT:     cmd.op = hbc_pkg::OP_BUILT;
         hbc_pkg::ST_ENC_RD:    cmd.op = hbc_pkg::OP_ENC_RD;
         hbc_pkg::ST_ENC_CAP:   cmd.op = hbc_pkg::OP_ENC_CAP;
         hbc_pkg::ST_DEC_RD:    cmd.op = hbc_pkg::OP_DEC_RD;
         hbc_pkg::ST_DEC_CAP:   cmd.op = hbc_pkg::OP_DEC_CAP;
         hbc_pkg::ST_RESP:      cmd.op = status.rsp_free ? hbc_pkg::OP_PUSH :
                                                           hbc_pkg::OP_NONE;
         default:               cmd.op = hbc_pkg::OP_NONE;
      endcase
   end

endmodule

FILE: rtl/hbc_datapath.sv
// ---------------------------------------------------------------------------
// Huffman engine datapath
// Count, node list, child and code path memories, scan comparators, the
// merge adder, decode position and the response register.
// ---------------------------------------------------------------------------
`include "huffman_table_builder_codec_top_macros.svh"

module hbc_datapath #(
   parameter int SYMBOL_COUNT  = 256,
   parameter int COUNT_BITS    = 24,
   parameter int MAX_CODE_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   hbc_req_if.sink                 req_bus,
   hbc_rsp_if.source               rsp_bus,
   input  hbc_pkg::hbc_cmd_type    cmd,
   output hbc_pkg::hbc_status_type status
);

   localparam int SW    = $clog2(SYMBOL_COUNT);
   localparam int SW1   = SW + 1;
   localparam int NODES = 2 * SYMBOL_COUNT - 1;
   localparam int NW    = $clog2(NODES);
   localparam int WW    = COUNT_BITS + SW;
   localparam int AEW   = WW + NW;
   localparam int LW    = $clog2(MAX_CODE_BITS + 2);
   localparam int PW    = MAX_CODE_BITS;
   localparam int PEW   = LW + PW;
   localparam int BW    = hbc_pkg::BYTE_W + 1;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [NW-1:0]  N_NODE     = NW'(SYMBOL_COUNT);
   localparam logic [NW-1:0]  ROOT_NODE  = NW'(NODES - 1);
   localparam logic [SW1-1:0] N_CNT      = SW1'(SYMBOL_COUNT);
   localparam logic [SW-1:0]  LAST_SYM   = SW'(SYMBOL_COUNT - 1);
   localparam logic [BW-1:0]  N_BYTE     = BW'(SYMBOL_COUNT);
   localparam logic [LW-1:0]  LEN_LIMIT  = LW'(MAX_CODE_BITS + 1);

   // Request capture and persistent state
   logic [hbc_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [hbc_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                       bit_ff, bit_in;
   logic                       built_ff, built_in;
   logic [NW-1:0]              dec_pos_ff, dec_pos_in;
   logic [SYMBOL_COUNT-1:0]    cnt_vld_ff, cnt_vld_in;

   // Build counters and scan registers
   logic [SW-1:0]  i_ff, i_in;
   logic [SW1-1:0] j_ff, j_in;
   logic [SW1-1:0] count_ff, count_in;
   logic [NW-1:0]  next_ff, next_in;
   logic [NW-1:0]  k_ff, k_in;
   logic [AEW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [SW-1:0]  lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in;
   logic           hi_vld_ff, hi_vld_in;

   // Result under construction and the output register
   logic                       res_status_ff, res_status_in;
   logic [hbc_pkg::CODE_W-1:0] res_code_ff, res_code_in;
   logic [hbc_pkg::LEN_W-1:0]  res_len_ff, res_len_in;
   logic [hbc_pkg::SYM_W-1:0]  res_sym_ff, res_sym_in;
   logic                       res_svld_ff, res_svld_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic [hbc_pkg::CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [hbc_pkg::LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [hbc_pkg::SYM_W-1:0]  rsp_sym_ff, rsp_sym_in;
   logic                       rsp_svld_ff, rsp_svld_in;

   // Memory ports
   logic                  cnt_we;
   logic [SW-1:0]         cnt_addr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
   logic                  act_we;
   logic [SW-1:0]         act_waddr, act_raddr;
   logic [AEW-1:0]        act_wdata, act_rd;
   logic                  kid_we;
   logic [SW-1:0]         kid_waddr, kid_raddr;
   logic [2*NW-1:0]       kid_wdata, kid_rd;
   logic                  path_we;
   logic [NW-1:0]         path_waddr, path_raddr;
   logic [PEW-1:0]        path_wdata, path_rd;

   // Helpers
   logic                  accept;
   logic                  sym_ok;
   logic [SW-1:0]         sym_idx;
   logic [COUNT_BITS-1:0] cnt_cur;
   logic [WW-1:0]         init_weight;
   logic [SW-1:0]         scan_idx;
   logic [WW-1:0]         merge_sum;
   logic [NW-1:0]         next_off, k_off, pos_off;
   logic [NW-1:0]         kid_l, kid_r, dec_child;
   logic [LW-1:0]         path_len, path_len_next;
   logic [PW-1:0]         path_bits;

   hbc_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOL_COUNT)) u_cnt_ram (
      .clock  (clock),
      .wr_en  (cnt_we),
      .wr_addr(cnt_addr),
      .wr_data(cnt_wdata),
      .rd_addr(cnt_addr),
      .rd_data(cnt_rd)
   );

   hbc_ram #(.WIDTH(AEW), .DEPTH(SYMBOL_COUNT)) u_act_ram (
      .clock  (clock),
      .wr_en  (act_we),
      .wr_addr(act_waddr),
      .wr_data(act_wdata),
      .rd_addr(act_raddr),
      .rd_data(act_rd)
   );

   hbc_ram #(.WIDTH(2 * NW), .DEPTH(SYMBOL_COUNT)) u_kid_ram (
      .clock  (clock),
      .wr_en  (kid_we),
      .wr_addr(kid_waddr),
      .wr_data(kid_wdata),
      .rd_addr(kid_raddr),
      .rd_data(kid_rd)
   );

   hbc_ram #(.WIDTH(PEW), .DEPTH(NODES)) u_path_ram (
      .clock  (clock),
      .wr_en  (path_we),
      .wr_addr(path_waddr),
      .wr_data(path_wdata),
      .rd_addr(path_raddr),
      .rd_data(path_rd)
   );

   assign accept   = req_bus.valid && cmd.req_ready;
   assign sym_ok   = {1'b0, byte_ff} < N_BYTE;
   assign sym_idx  = byte_ff[SW-1:0];
   assign cnt_addr = (kind_ff == hbc_pkg::KIND_BUILD) ? i_ff : sym_idx;
   // A count whose valid bit is clear reads as zero since the last clear.
   assign cnt_cur  = cnt_vld_ff[cnt_addr] ? cnt_rd : '0;
   assign cnt_wdata = cnt_cur + COUNT_BITS'(1);
   assign init_weight = (cnt_cur == '0) ? WW'(1) : WW'(cnt_cur);

   assign scan_idx  = SW'(j_ff - SW1'(1));
   assign merge_sum = lo_ff[AEW-1:NW] + hi_ff[AEW-1:NW];
   assign next_off  = next_ff - N_NODE;
   assign k_off     = k_ff - N_NODE;
   assign pos_off   = dec_pos_ff - N_NODE;
   assign kid_l     = kid_rd[2*NW-1:NW];
   assign kid_r     = kid_rd[NW-1:0];
   assign dec_child = bit_ff ? kid_r : kid_l;
   assign path_len  = path_rd[PEW-1:PW];
   assign path_bits = path_rd[PW-1:0];
   // Depth saturates one past the longest code so that deep nodes stay marked.
   assign path_len_next = (path_len >= LEN_LIMIT) ? LEN_LIMIT : path_len + LW'(1);

   assign act_raddr  = (cmd.op == hbc_pkg::OP_MERGE_RD) ? count_ff[SW-1:0] : j_ff[SW-1:0];
   assign kid_raddr  = (kind_ff == hbc_pkg::KIND_DECODE) ? pos_off[SW-1:0] : k_off[SW-1:0];
   assign path_raddr = (kind_ff == hbc_pkg::KIND_ENCODE) ? NW'(sym_idx) : k_ff;

   always_comb begin
      kind_in       = kind_ff;
      byte_in       = byte_ff;
      bit_in        = bit_ff;
      built_in      = built_ff;
      dec_pos_in    = dec_pos_ff;
      cnt_vld_in    = cnt_vld_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      count_in      = count_ff;
      next_in       = next_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      lo_idx_in     = lo_idx_ff;
      hi_idx_in     = hi_idx_ff;
      hi_vld_in     = hi_vld_ff;
      res_status_in = res_status_ff;
      res_code_in   = res_code_ff;
      res_len_in    = res_len_ff;
      res_sym_in    = res_sym_ff;
      res_svld_in   = res_svld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_svld_in   = rsp_svld_ff;
      cnt_we        = 1'b0;
      act_we        = 1'b0;
      act_waddr     = i_ff;
      act_wdata     = {init_weight, NW'(i_ff)};
      kid_we        = 1'b0;
      kid_waddr     = next_off[SW-1:0];
      kid_wdata     = {lo_ff[NW-1:0], hi_ff[NW-1:0]};
      path_we       = 1'b0;
      path_waddr    = kid_l;
      path_wdata    = {path_len_next, path_bits << 1};

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (cmd.op)
         hbc_pkg::OP_ACCEPT: begin
            if (accept) begin
               kind_in       = req_bus.kind;
               byte_in       = req_bus.byte_value;
               bit_in        = req_bus.code_bit;
               i_in          = '0;
               res_status_in = !built_ff && (req_bus.kind == hbc_pkg::KIND_ENCODE ||
                                             req_bus.kind == hbc_pkg::KIND_DECODE);
               res_code_in   = '0;
               res_len_in    = '0;
               res_sym_in    = '0;
               res_svld_in   = 1'b0;
            end
         end
         hbc_pkg::OP_CLEAR: begin
            cnt_vld_in = '0;
            built_in   = 1'b0;
         end
         hbc_pkg::OP_CNT_WR: begin
            built_in = 1'b0;
            if (sym_ok && cnt_cur != CNT_MAX) begin
               cnt_we              = 1'b1;
               cnt_vld_in[sym_idx] = 1'b1;
            end
         end
         hbc_pkg::OP_INIT_WR: begin
            act_we = 1'b1;
            i_in   = i_ff + SW'(1);
            if (i_ff == LAST_SYM) begin
               j_in     = '0;
               count_in = N_CNT;
               next_in  = N_NODE;
            end
         end
         hbc_pkg::OP_SCAN, hbc_pkg::OP_SCAN_TAIL: begin
            if (cmd.op == hbc_pkg::OP_SCAN) begin
               j_in = j_ff + SW1'(1);
            end
            // Entries are {weight, node}, so one compare orders by weight then number.
            if (j_ff == SW1'(1)) begin
               lo_in     = act_rd;
               lo_idx_in = scan_idx;
               hi_vld_in = 1'b0;
            end else if (j_ff != '0) begin
               if (act_rd < lo_ff) begin
                  hi_in     = lo_ff;
                  hi_idx_in = lo_idx_ff;
                  hi_vld_in = 1'b1;
                  lo_in     = act_rd;
                  lo_idx_in = scan_idx;
               end else if (!hi_vld_ff || act_rd < hi_ff) begin
                  hi_in     = act_rd;
                  hi_idx_in = scan_idx;
                  hi_vld_in = 1'b1;
               end
            end
         end
         hbc_pkg::OP_MERGE_LO: begin
            kid_we    = 1'b1;
            act_we    = 1'b1;
            act_waddr = lo_idx_ff;
            act_wdata = {merge_sum, next_ff};
            count_in  = count_ff - SW1'(1);
         end
         hbc_pkg::OP_MERGE_HI: begin
            // The last list entry moves into the slot of the right child.
            act_we    = 1'b1;
            act_waddr = hi_idx_ff;
            act_wdata = act_rd;
            next_in   = next_ff + NW'(1);
            j_in      = '0;
         end
         hbc_pkg::OP_WALK_INIT: begin
            path_we    = 1'b1;
            path_waddr = ROOT_NODE;
            path_wdata = '0;
            k_in       = ROOT_NODE;
         end
         hbc_pkg::OP_WALK_L: begin
            path_we = 1'b1;
         end
         hbc_pkg::OP_WALK_R: begin
            path_we    = 1'b1;
            path_waddr = kid_r;
            path_wdata = {path_len_next, path_bits << 1} | PEW'(1);
            k_in       = k_ff - NW'(1);
         end
         hbc_pkg::OP_BUILT: begin
            built_in   = 1'b1;
            dec_pos_in = ROOT_NODE;
         end
         hbc_pkg::OP_ENC_CAP: begin
            if (path_len < LEN_LIMIT) begin
               res_code_in = hbc_pkg::CODE_W'(path_bits);
               res_len_in  = hbc_pkg::LEN_W'(path_len);
            end
         end
         hbc_pkg::OP_DEC_CAP: begin
            if (dec_child < N_NODE) begin
               res_sym_in  = hbc_pkg::SYM_W'(dec_child);
               res_svld_in = 1'b1;
               dec_pos_in  = ROOT_NODE;
            end else begin
               dec_pos_in = dec_child;
            end
         end
         hbc_pkg::OP_PUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_code_in   = res_code_ff;
            rsp_len_in    = res_len_ff;
            rsp_sym_in    = res_sym_ff;
            rsp_svld_in   = res_svld_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff     <= 1'b0;
         dec_pos_ff   <= ROOT_NODE;
         cnt_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= hbc_pkg::KIND_CLEAR;
      end else begin
         built_ff     <= built_in;
         dec_pos_ff   <= dec_pos_in;
         cnt_vld_ff   <= cnt_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      bit_ff        <= bit_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      count_ff      <= count_in;
      next_ff       <= next_in;
      k_ff          <= k_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      lo_idx_ff     <= lo_idx_in;
      hi_idx_ff     <= hi_idx_in;
      hi_vld_ff     <= hi_vld_in;
      res_status_ff <= res_status_in;
      res_code_ff   <= res_code_in;
      res_len_ff    <= res_len_in;
      res_sym_ff    <= res_sym_in;
      res_svld_ff   <= res_svld_in;
      rsp_status_ff <= rsp_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_svld_ff   <= rsp_svld_in;
   end

   assign req_bus.ready        = cmd.req_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.code_bits    = rsp_code_ff;
   assign rsp_bus.code_length  = rsp_len_ff;
   assign rsp_bus.symbol       = rsp_sym_ff;
   assign rsp_bus.symbol_valid = rsp_svld_ff;

   assign status.req_valid  = req_bus.valid;
   assign status.req_kind   = hbc_pkg::hbc_kind_type'(req_bus.kind);
   assign status.req_sym_ok = {1'b0, req_bus.byte_value} < N_BYTE;
   assign status.built      = built_ff;
   assign status.init_last  = (i_ff == LAST_SYM);
   assign status.scan_last  = (j_ff == count_ff - SW1'(1));
   assign status.count_one  = (count_ff == SW1'(1));
   assign status.walk_last  = (k_ff == N_NODE);
   assign status.rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   `HBC_ASSERT_ALWAYS(a_dec_pos_internal, clock, reset, dec_pos_ff >= N_NODE, "decode position left the internal nodes")
   `HBC_ASSERT_IMPLY(a_merge_distinct, clock, reset, cmd.op == hbc_pkg::OP_MERGE_LO, hi_vld_ff && lo_idx_ff != hi_idx_ff, "merge picked the same list slot twice")
   `HBC_ASSERT_NEXT(a_build_done, clock, reset, cmd.op == hbc_pkg::OP_BUILT, built_ff && dec_pos_ff == ROOT_NODE, "build finished without marking the table")

endmodule

FILE: rtl/huffman_table_builder_codec_top.sv
// ---------------------------------------------------------------------------
// Byte Huffman engine
// Clears and counts symbols, builds a Huffman code, encodes symbols and decodes bits.
// ---------------------------------------------------------------------------
// Requests arrive on req_bus (kind, byte_value, code_bit); every request gives
// exactly one response on rsp_bus (status, code_bits, code_length, symbol,
// symbol_valid). Both channels transfer when valid and ready are high.
// One request is worked on at a time. A clear, count, encode or decode
// request passes through its own states before the response; an encode or
// decode without a built code, an encode of a symbol outside the table and
// kinds without meaning go straight to the response. The next request can
// be taken in the cycle after the response is loaded. A build scans the node
// list once per merge through one read port of the list memory.
// The response sits in an output register; the next request is accepted while
// it waits, and only the following response waits for rsp_bus.ready.
// Reset clears all counts (per-symbol valid bits), returns the decode position
// to the root and marks the code as not built; no clearing pass is needed.
// ---------------------------------------------------------------------------
module huffman_table_builder_codec_top #(
   parameter int SYMBOL_COUNT  = 256,
   parameter int COUNT_BITS    = 24,
   parameter int MAX_CODE_BITS = 64
) (
   input  logic      clock,
   input  logic      reset,
   hbc_req_if.sink   req_bus,
   hbc_rsp_if.source rsp_bus
);

   hbc_pkg::hbc_cmd_type    cmd;
   hbc_pkg::hbc_status_type status;

   hbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .cmd   (cmd)
   );

   hbc_datapath #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .COUNT_BITS   (COUNT_BITS),
      .MAX_CODE_BITS(MAX_CODE_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .cmd    (cmd),
      .status (status)
   );

endmodule
